// ----- design/intrusion_alarm_controller_macros.svh -----
// Assertion macros shared by the alarm controller RTL.
`ifndef INTRUSION_ALARM_CONTROLLER_MACROS_SVH
`define INTRUSION_ALARM_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define IAC_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("iac check failed: same-cycle rule");

// Next-cycle implication, checked on every clock edge outside reset.
`define IAC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("iac check failed: next-cycle rule");

`endif

// ----- design/iac_pkg.sv -----
// Shared widths, request and mode codes, and register indexes for the alarm controller.
package iac_pkg;

  localparam int SENSOR_SLOTS = 6;
  localparam int REQ_W        = 2;
  localparam int MODE_W       = 3;
  localparam int IDX_W        = 3;
  localparam int KIND_W       = 2;
  localparam int KINDS_W      = 12;
  localparam int SEC_W        = 8;
  localparam int MS_W         = 10;
  localparam int BLINK_W      = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ARM    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DISARM = 2'd2;
  localparam logic [REQ_W-1:0] REQ_OK     = 2'd3;

  // panel modes
  localparam logic [MODE_W-1:0] MODE_DISARMED = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ARMED    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ARMING   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ALARM    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SHOWN    = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_KINDS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_DELAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_MS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIRP_MS     = 3'd4;

  // register reset values
  localparam logic [SENSOR_SLOTS-1:0] ENABLE_MASK_RST  = 6'd15;
  localparam logic [KINDS_W-1:0]      SENSOR_KINDS_RST = 12'd144;
  localparam logic [SEC_W-1:0]        EXIT_DELAY_RST   = 8'd10;
  localparam logic [BLINK_W-1:0]      BLINK_MS_RST     = 16'd250;
  localparam logic [MS_W-1:0]         CHIRP_MS_RST     = 10'd50;

  localparam logic [MS_W-1:0]  MS_PER_SECOND = 10'd1000;
  localparam logic [SEC_W-1:0] SEC_MAX       = 8'd255;

endpackage

// ----- design/iac_cmd_if.sv -----
// Command channel: request type and sensor levels, valid/ready handshake.
interface iac_cmd_if
  import iac_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [SENSOR_SLOTS-1:0] sensor_levels;

  modport source (output valid, output req_type, output sensor_levels, input ready);
  modport sink   (input valid, input req_type, input sensor_levels, output ready);
endinterface

// ----- design/iac_status_if.sv -----
// Status channel: panel mode, siren, chirp, countdown and violator, valid/ready handshake.
interface iac_status_if
  import iac_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode_code;
  logic              siren_on;
  logic              chirp_on;
  logic [SEC_W-1:0]  seconds_left;
  logic [IDX_W-1:0]  violator_index;
  logic [KIND_W-1:0] violator_kind;

  modport source (output valid, output mode_code, output siren_on, output chirp_on,
                  output seconds_left, output violator_index, output violator_kind,
                  input ready);
  modport sink   (input valid, input mode_code, input siren_on, input chirp_on,
                  input seconds_left, input violator_index, input violator_kind,
                  output ready);
endinterface

// ----- design/intrusion_alarm_controller.sv -----
// Alarm panel core: command register, single-pass mode update, status register.
//
// Usage:
// - cmd carries one beat per event: a millisecond tick with the sensor levels,
//   an arm request, a disarm request or an OK press.
// - status returns exactly one beat per cmd beat, the panel view after that event.
// - cfg_we/cfg_index/cfg_data write the five setup registers (mask, kinds, exit
//   delay, blink period, chirp length); write them only while the block is idle.
// Timing:
// - A cmd beat lands in the command register; the edge that advances it out runs
//   the mode update and loads the status register, which raises status.valid.
// - One beat per cycle sustained while status.ready holds; the rate is set by the
//   one-pass next-state logic between the command register and the status register.
// Reset (rst, synchronous): panel disarmed, counters and siren cleared,
//   violator 0, setup registers back to their defaults, both stages empty.
// Backpressure: a stalled status beat holds; the command register still takes
//   one more beat, and cmd.ready drops only when both stages are full.
`include "intrusion_alarm_controller_macros.svh"

module intrusion_alarm_controller
  import iac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  iac_cmd_if.sink               cmd,
  iac_status_if.source          status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // setup registers
  logic [SENSOR_SLOTS-1:0] enable_mask;
  logic [KINDS_W-1:0]      sensor_kinds;
  logic [SEC_W-1:0]        exit_delay_s;
  logic [BLINK_W-1:0]      blink_ms;
  logic [MS_W-1:0]         chirp_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask  <= ENABLE_MASK_RST;
      sensor_kinds <= SENSOR_KINDS_RST;
      exit_delay_s <= EXIT_DELAY_RST;
      blink_ms     <= BLINK_MS_RST;
      chirp_ms     <= CHIRP_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE_MASK:  enable_mask  <= cfg_data[SENSOR_SLOTS-1:0];
        CFG_SENSOR_KINDS: sensor_kinds <= cfg_data[KINDS_W-1:0];
        CFG_EXIT_DELAY:   exit_delay_s <= cfg_data[SEC_W-1:0];
        CFG_BLINK_MS:     blink_ms     <= cfg_data[BLINK_W-1:0];
        CFG_CHIRP_MS:     chirp_ms     <= cfg_data[MS_W-1:0];
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  // command register
  logic                    cmd_valid;
  logic [REQ_W-1:0]        cmd_req;
  logic [SENSOR_SLOTS-1:0] cmd_levels;
  logic                    advance;

  assign advance   = cmd_valid && (!status.valid || status.ready);
  assign cmd.ready = !cmd_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd.ready) begin
      cmd_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      cmd_req    <= cmd.req_type;
      cmd_levels <= cmd.sensor_levels;
    end
  end

  // panel state
  logic [MODE_W-1:0]  mode, mode_next;
  logic [MS_W-1:0]    ms_in_second, ms_in_second_next;
  logic [SEC_W-1:0]   elapsed_seconds, elapsed_seconds_next;
  logic [BLINK_W-1:0] blink_count, blink_count_next;
  logic               siren, siren_next;
  logic [IDX_W-1:0]   violator, violator_next;

  // lowest enabled sensor that is high
  logic [SENSOR_SLOTS-1:0] hits;
  logic                    hit_found;
  logic [IDX_W-1:0]        hit_idx;

  assign hits = cmd_levels & enable_mask;

  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int i = SENSOR_SLOTS - 1; i >= 0; i--) begin
      if (hits[i]) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(i);
      end
    end
  end

  logic [BLINK_W-1:0] blink_inc;
  logic [BLINK_W-1:0] blink_period;
  logic [MS_W-1:0]    ms_inc;
  logic [SEC_W-1:0]   elapsed_inc;
  logic               busy;

  assign blink_inc    = blink_count + 1'b1;
  assign blink_period = (blink_ms == '0) ? BLINK_W'(1) : blink_ms;
  assign ms_inc       = ms_in_second + 1'b1;
  assign elapsed_inc  = (elapsed_seconds < SEC_MAX) ? elapsed_seconds + 1'b1
                                                    : elapsed_seconds;
  assign busy         = (mode == MODE_ARMING) || (mode == MODE_ALARM);

  always_comb begin
    mode_next            = mode;
    ms_in_second_next    = ms_in_second;
    elapsed_seconds_next = elapsed_seconds;
    blink_count_next     = blink_count;
    siren_next           = siren;
    violator_next        = violator;
    unique case (cmd_req)
      REQ_TICK: begin
        if (mode == MODE_ALARM) begin
          // siren blink; a wrapped count also toggles
          if (blink_inc >= blink_period || blink_inc == '0) begin
            blink_count_next = '0;
            siren_next       = !siren;
          end else begin
            blink_count_next = blink_inc;
          end
        end else if (mode == MODE_ARMING) begin
          // violations ignored during exit countdown
          if (ms_inc >= MS_PER_SECOND) begin
            ms_in_second_next = '0;
            if (elapsed_inc > exit_delay_s) mode_next = MODE_ARMED;
            elapsed_seconds_next = elapsed_inc;
          end else begin
            ms_in_second_next = ms_inc;
            if (elapsed_seconds > exit_delay_s) mode_next = MODE_ARMED;
          end
        end else if (hit_found) begin
          if (mode == MODE_ARMED) begin
            mode_next        = MODE_ALARM;
            violator_next    = hit_idx;
            blink_count_next = '0;
            siren_next       = 1'b1;
          end else if (mode == MODE_DISARMED) begin
            mode_next     = MODE_SHOWN;
            violator_next = hit_idx;
          end
        end else if (mode == MODE_SHOWN) begin
          mode_next = MODE_DISARMED;
        end
      end
      REQ_ARM: begin
        if (!busy) begin
          mode_next            = MODE_ARMING;
          ms_in_second_next    = '0;
          elapsed_seconds_next = '0;
          siren_next           = 1'b0;
          blink_count_next     = '0;
        end
      end
      REQ_DISARM: begin
        if (!busy) mode_next = MODE_DISARMED;
      end
      REQ_OK: begin
        if (busy) begin
          mode_next  = MODE_DISARMED;
          siren_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_DISARMED;
      ms_in_second    <= '0;
      elapsed_seconds <= '0;
      blink_count     <= '0;
      siren           <= 1'b0;
      violator        <= '0;
    end else if (advance) begin
      mode            <= mode_next;
      ms_in_second    <= ms_in_second_next;
      elapsed_seconds <= elapsed_seconds_next;
      blink_count     <= blink_count_next;
      siren           <= siren_next;
      violator        <= violator_next;
    end
  end

  // status view of the updated state
  logic              arming_next;
  logic [SEC_W-1:0]  left_next;
  logic              chirp_next;
  logic [KINDS_W-1:0] kinds_shifted;

  assign arming_next   = (mode_next == MODE_ARMING);
  assign left_next     = (arming_next && elapsed_seconds_next <= exit_delay_s)
                         ? exit_delay_s - elapsed_seconds_next : '0;
  assign chirp_next    = arming_next && (ms_in_second_next < chirp_ms);
  assign kinds_shifted = sensor_kinds >> {violator_next, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      status.valid <= 1'b0;
    end else if (advance) begin
      status.valid <= 1'b1;
    end else if (status.ready) begin
      status.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status.mode_code      <= mode_next;
      status.siren_on       <= (mode_next == MODE_ALARM) && siren_next;
      status.chirp_on       <= chirp_next;
      status.seconds_left   <= left_next;
      status.violator_index <= violator_next;
      status.violator_kind  <= kinds_shifted[KIND_W-1:0];
    end
  end

  // checks
  `IAC_ASSERT_NOW(a_siren_only_in_alarm, status.valid && status.siren_on,
                  status.mode_code == MODE_ALARM)
  `IAC_ASSERT_NOW(a_countdown_only_arming, status.valid && status.seconds_left != '0,
                  status.mode_code == MODE_ARMING)
  `IAC_ASSERT_NEXT(a_advance_fills_status, advance, status.valid)
  `IAC_ASSERT_NOW(a_full_blocks_cmd, cmd_valid && !advance, !cmd.ready)

endmodule
